>>> src/shn_pkg.sv
// ----------------------------------------------------------------------------
// shn_pkg: shared types and constants of the sample histogram normalizer
// Widths, register codes, item structs and the cell/divider control groups.
// ----------------------------------------------------------------------------
package shn_pkg;

  localparam int unsigned MaxGroups = 16;
  localparam int unsigned IdxW      = $clog2(MaxGroups);
  localparam int unsigned NumW      = $clog2(MaxGroups + 1);

  localparam int unsigned SampleW = 16;
  localparam int unsigned CountW  = 16;
  localparam int unsigned ShareW  = 17;
  localparam int unsigned ThrW    = SampleW + 1;
  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;

  localparam int unsigned DivNumW = 2 * CountW;
  localparam int unsigned DivDenW = CountW;
  localparam int unsigned DivCntW = $clog2(DivNumW);

  // register indexes
  localparam logic [CfgIdxW-1:0] RegMaxInput  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegNumGroups = 2'd1;

  localparam logic [SampleW-1:0] MaxInputRst  = 16'd1023;
  localparam logic [NumW-1:0]    NumGroupsRst = 5'd8;

  typedef struct packed {
    logic [SampleW-1:0] sample;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic [IdxW-1:0]   group_index;
    logic [CountW-1:0] group_count;
    logic [ShareW-1:0] share_of_largest;
    logic              last_group;
  } out_item_t;

  // sample token walking down the cell row
  typedef struct packed {
    logic               valid;
    logic               last;
    logic               done;
    logic [SampleW-1:0] sample;
    logic [CountW-1:0]  top;
  } tok_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctl_t;

  typedef struct packed {
    logic               start;
    logic [DivNumW-1:0] num;
    logic [DivDenW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic               busy;
    logic               done;
    logic [DivNumW-1:0] quo;
  } div_rsp_t;

endpackage

>>> src/shn_div.sv
// ----------------------------------------------------------------------------
// shn_div: radix-2 restoring divider
// One quotient bit per cycle from start to done.
// ----------------------------------------------------------------------------
module shn_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  shn_pkg::div_req_t req_i,
  output shn_pkg::div_rsp_t rsp_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [shn_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic [shn_pkg::DivNumW-1:0] quo_q, quo_d;
  logic [shn_pkg::DivDenW-1:0] rem_q, rem_d;
  logic [shn_pkg::DivDenW-1:0] den_q, den_d;
  logic [shn_pkg::DivDenW:0]   rem_sh;
  logic                        fits;

  assign rem_sh = {rem_q, quo_q[shn_pkg::DivNumW-1]};
  assign fits   = rem_sh >= {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      quo_d  = req_i.num;
      rem_d  = '0;
      den_d  = req_i.den;
    end else if (busy_q) begin
      // remainder stays below the divisor, so the top bit drops after subtract
      rem_d = fits ? shn_pkg::DivDenW'(rem_sh - {1'b0, den_q})
                   : rem_sh[shn_pkg::DivDenW-1:0];
      quo_d = {quo_q[shn_pkg::DivNumW-2:0], fits};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == shn_pkg::DivCntW'(shn_pkg::DivNumW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign rsp_o.busy = busy_q;
  assign rsp_o.done = done_q;
  assign rsp_o.quo  = quo_q;

endmodule

>>> src/shn_cell.sv
// ----------------------------------------------------------------------------
// shn_cell: one histogram bin
// Holds a bin count and its threshold; takes the sample token from its left
// neighbor, counts it on a first hit, carries the running maximum in the token
// and shifts counts toward bin 0 during readout.
// ----------------------------------------------------------------------------
module shn_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  shn_pkg::tok_t              tok_i,
  output shn_pkg::tok_t              tok_o,
  input  logic [shn_pkg::ThrW-1:0]   thr_i,
  input  logic [shn_pkg::ThrW-1:0]   width_i,
  output logic [shn_pkg::ThrW-1:0]   thr_o,
  input  logic                       in_use_i,
  input  shn_pkg::cell_ctl_t         ctl_i,
  input  logic [shn_pkg::CountW-1:0] cnt_i,
  output logic [shn_pkg::CountW-1:0] cnt_o
);

  shn_pkg::tok_t              tok_q;
  logic [shn_pkg::ThrW-1:0]   thr_q, thr_d;
  logic [shn_pkg::CountW-1:0] cnt_q, cnt_d;
  logic [shn_pkg::CountW-1:0] cnt_new;
  logic                       hit;

  // threshold is the left neighbor's threshold plus the width, registered per cell
  assign thr_d = thr_i + width_i;

  assign hit = tok_q.valid && !tok_q.done && in_use_i &&
               ({1'b0, tok_q.sample} <= thr_q);

  always_comb begin
    cnt_new = cnt_q;
    if (hit && (cnt_q != '1)) begin
      cnt_new = cnt_q + 1'b1;
    end
    if (ctl_i.clear) begin
      cnt_d = '0;
    end else if (ctl_i.shift) begin
      cnt_d = cnt_i;
    end else begin
      cnt_d = cnt_new;
    end
  end

  always_comb begin
    tok_o      = tok_q;
    tok_o.done = tok_q.done | hit;
    if (in_use_i && (cnt_new > tok_q.top)) begin
      tok_o.top = cnt_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      cnt_q <= '0;
    end else begin
      tok_q <= tok_i;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q <= thr_d;
  end

  assign thr_o = thr_q;
  assign cnt_o = cnt_q;

endmodule

>>> src/sample_histogram_normalizer.sv
// ----------------------------------------------------------------------------
// sample_histogram_normalizer: equal-width histogram with normalized shares
// A row of bin cells counts samples; on the last sample of a set each bin in
// use is read out with its count and its share of the largest bin.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  cfg     | in        | cfg_valid_i/ready_o   | cfg_index_i, cfg_data_i
//  in      | in        | in_valid_i/ready_o    | in_item_i (sample, last)
//  out     | out       | out_valid_o/ready_i   | out_item_o (one item per bin)
//
//  Samples enter one per cycle while in_ready_o is high and walk the 16-cell
//  row, one cell per cycle. After a last sample, input stalls while it crosses
//  the row and during readout: for each bin in use S_DGO starts the shared
//  32-step divider, S_DIV waits until its quotient is registered, and S_WAIT
//  loads the output register, waiting while it is full and out_ready_i is low.
//  After reset and after each config write the bin width is recomputed on the
//  same divider and the thresholds ripple down the row, with input and config
//  not ready.
// ----------------------------------------------------------------------------
module sample_histogram_normalizer (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [shn_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [shn_pkg::CfgW-1:0]    cfg_data_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  shn_pkg::in_item_t           in_item_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output shn_pkg::out_item_t          out_item_o
);

  localparam int unsigned MG = shn_pkg::MaxGroups;

  localparam logic [2:0] S_WSTART = 3'd0;
  localparam logic [2:0] S_WDIV   = 3'd1;
  localparam logic [2:0] S_SETTLE = 3'd2;
  localparam logic [2:0] S_RUN    = 3'd3;
  localparam logic [2:0] S_DGO    = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_WAIT   = 3'd6;

  logic [2:0]                  state_q, state_d;
  logic [shn_pkg::SampleW-1:0] max_input_q, max_input_d;
  logic [shn_pkg::NumW-1:0]    num_groups_q, num_groups_d;
  logic [shn_pkg::NumW-1:0]    n_use;
  logic [shn_pkg::ThrW-1:0]    width_q, width_d;
  logic [shn_pkg::NumW-1:0]    settle_q, settle_d;
  logic                        inflight_q, inflight_d;
  logic [shn_pkg::CountW-1:0]  top_q, top_d;
  logic [shn_pkg::IdxW-1:0]    idx_q, idx_d;
  logic [shn_pkg::ShareW-1:0]  share_q, share_d;
  logic                        out_valid_q, out_valid_d;
  shn_pkg::out_item_t          out_q, out_d;

  shn_pkg::div_req_t  div_req;
  shn_pkg::div_rsp_t  div_rsp;
  shn_pkg::cell_ctl_t cell_ctl;

  shn_pkg::tok_t              tok_in  [MG+1];
  logic [shn_pkg::ThrW-1:0]   thr_in  [MG+1];
  logic [shn_pkg::CountW-1:0] cnt_o   [MG];
  logic [MG-1:0]              in_use;
  logic [MG-1:0]              cell_valid;
  logic                       chain_busy;
  logic                       cfg_fire;
  logic                       in_fire;
  logic                       exit_last;
  logic                       is_last_bin;

  always_comb begin
    n_use = num_groups_q;
    if (num_groups_q == '0) begin
      n_use = shn_pkg::NumW'(1);
    end else if (num_groups_q > shn_pkg::NumW'(MG)) begin
      n_use = shn_pkg::NumW'(MG);
    end
  end

  assign chain_busy  = |cell_valid;
  assign cfg_ready_o = (state_q == S_RUN) && !chain_busy && !inflight_q;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == S_RUN) && !inflight_q && !cfg_fire;
  assign in_fire     = in_valid_i && in_ready_o;

  always_comb begin
    tok_in[0]        = '0;
    tok_in[0].valid  = in_fire;
    tok_in[0].last   = in_item_i.last_sample;
    tok_in[0].sample = in_item_i.sample;
    thr_in[0]        = '0;
  end

  for (genvar k = 0; k < MG; k++) begin : g_cell
    logic [shn_pkg::CountW-1:0] cnt_right;

    assign in_use[k]     = shn_pkg::NumW'(k) < n_use;
    assign cell_valid[k] = tok_in[k+1].valid;
    if (k == MG - 1) begin : g_end
      assign cnt_right = '0;
    end else begin : g_mid
      assign cnt_right = cnt_o[k+1];
    end

    shn_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .tok_i    (tok_in[k]),
      .tok_o    (tok_in[k+1]),
      .thr_i    (thr_in[k]),
      .width_i  (width_q),
      .thr_o    (thr_in[k+1]),
      .in_use_i (in_use[k]),
      .ctl_i    (cell_ctl),
      .cnt_i    (cnt_right),
      .cnt_o    (cnt_o[k])
    );
  end

  assign exit_last   = tok_in[MG].valid && tok_in[MG].last;
  assign is_last_bin = {1'b0, idx_q} == (n_use - 1'b1);

  shn_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_comb begin
    div_req = '0;
    if (state_q == S_WSTART) begin
      div_req.start = 1'b1;
      div_req.num   = shn_pkg::DivNumW'({1'b0, max_input_q} + 1'b1);
      div_req.den   = shn_pkg::DivDenW'(n_use);
    end else if (state_q == S_DGO) begin
      div_req.start = 1'b1;
      div_req.num   = {cnt_o[0], {shn_pkg::CountW{1'b0}}};
      div_req.den   = top_q;
    end
  end

  always_comb begin
    state_d      = state_q;
    max_input_d  = max_input_q;
    num_groups_d = num_groups_q;
    width_d      = width_q;
    settle_d     = settle_q;
    inflight_d   = inflight_q;
    top_d        = top_q;
    idx_d        = idx_q;
    share_d      = share_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    cell_ctl     = '0;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_WSTART: begin
        state_d = S_WDIV;
      end
      S_WDIV: begin
        if (div_rsp.done) begin
          width_d  = div_rsp.quo[shn_pkg::ThrW-1:0];
          settle_d = '0;
          state_d  = S_SETTLE;
        end
      end
      S_SETTLE: begin
        settle_d = settle_q + 1'b1;
        if (settle_q == shn_pkg::NumW'(MG)) begin
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        if (cfg_fire) begin
          case (cfg_index_i)
            shn_pkg::RegMaxInput:  max_input_d  = cfg_data_i;
            shn_pkg::RegNumGroups: num_groups_d = cfg_data_i[shn_pkg::NumW-1:0];
            default: ;
          endcase
          state_d = S_WSTART;
        end
        if (in_fire && in_item_i.last_sample) begin
          inflight_d = 1'b1;
        end
        if (exit_last) begin
          inflight_d = 1'b0;
          top_d      = tok_in[MG].top;
          idx_d      = '0;
          state_d    = S_DGO;
        end
      end
      S_DGO: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_rsp.done) begin
          share_d = (top_q == '0) ? '0 : div_rsp.quo[shn_pkg::ShareW-1:0];
          state_d = S_WAIT;
        end
      end
      S_WAIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d            = 1'b1;
          out_d.group_index      = idx_q;
          out_d.group_count      = cnt_o[0];
          out_d.share_of_largest = share_q;
          out_d.last_group       = is_last_bin;
          if (is_last_bin) begin
            cell_ctl.clear = 1'b1;
            state_d        = S_RUN;
          end else begin
            cell_ctl.shift = 1'b1;
            idx_d          = idx_q + 1'b1;
            state_d        = S_DGO;
          end
        end
      end
      default: begin
        state_d = S_WSTART;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_WSTART;
      max_input_q  <= shn_pkg::MaxInputRst;
      num_groups_q <= shn_pkg::NumGroupsRst;
      settle_q     <= '0;
      inflight_q   <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      max_input_q  <= max_input_d;
      num_groups_q <= num_groups_d;
      settle_q     <= settle_d;
      inflight_q   <= inflight_d;
      idx_q        <= idx_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    width_q <= width_d;
    top_q   <= top_d;
    share_q <= share_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // nothing enters behind a last sample until its readout is done
  a_no_entry_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_item_i.last_sample) |=> !in_ready_o)
    else $error("sample accepted behind a last sample");

  // the last sample leaves the row with no other sample still inside
  a_last_exits_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exit_last |-> ($countones(cell_valid) == 1))
    else $error("samples in flight at readout start");

  // config only lands on an empty row
  a_cfg_on_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_fire |-> !chain_busy)
    else $error("config written with samples in flight");

  // a bin never exceeds the largest one
  a_share_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.share_of_largest <= 17'h10000))
    else $error("share above 1.0");

endmodule
